@@ hw/rtl/rpd_pkg.sv @@
// ----------------------------------------------------------------------------
// rpd_pkg
// Types and constants shared by the packet deframer modules and its checker.
// ----------------------------------------------------------------------------
package rpd_pkg;

	localparam int unsigned IdxW = 10;

	localparam logic [7:0] CH_START = 8'h24;
	localparam logic [7:0] CH_END   = 8'h23;
	localparam logic [7:0] CH_ACK   = 8'h2B;
	localparam logic [7:0] CH_NAK   = 8'h2D;

	localparam logic [1:0] KIND_PAYLOAD = 2'd0;
	localparam logic [1:0] KIND_ACCEPT  = 2'd1;
	localparam logic [1:0] KIND_REJECT  = 2'd2;

	localparam logic CMD_BYTE    = 1'b0;
	localparam logic CMD_RELEASE = 1'b1;

	typedef struct packed {
		logic       cmd;
		logic [7:0] rx_byte;
	} rpd_in_t;

	typedef struct packed {
		logic [1:0]      kind;
		logic [7:0]      data;
		logic [IdxW-1:0] payload_index;
		logic            overflow;
	} rpd_out_t;

	typedef enum logic [3:0] {
		PH_HUNT    = 4'b0001,
		PH_PAYLOAD = 4'b0010,
		PH_DIGITS  = 4'b0100,
		PH_HOLD    = 4'b1000
	} rpd_phase_t;

endpackage

@@ hw/rtl/rsp_packet_deframer.sv @@
// ----------------------------------------------------------------------------
// rsp_packet_deframer
// Deframes and checks remote-serial-protocol packets from a byte stream.
// ----------------------------------------------------------------------------
// Each request on the item channel is either a received byte or a release
// command. Bytes are discarded until a start character, then every payload
// byte is sent on the result channel with its index while a modulo-256 sum
// is kept. After the end character two hex digits are compared with the sum
// and one accept or reject result is sent. After an accept, bytes are ignored
// until a release request arrives.
// A request is registered on acceptance and decoded from that register into
// the result register once the result register is free to take it. One
// request is taken every cycle while the result channel is not stalled; the
// single decode stage and its packet state set that rate. Requests that cause
// no result still pass the same stage.
// Reset empties both registers and returns the block to hunting. When the
// receiver stalls the result register, the request stage holds and item_stall
// rises only if a request is waiting behind the held result.
// ----------------------------------------------------------------------------
module rsp_packet_deframer
	import rpd_pkg::*;
#(
	parameter int unsigned MAX_PAYLOAD = 1024
) (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     item_valid,
	output logic     item_stall,
	input  rpd_in_t  item,
	output logic     result_valid,
	input  logic     result_stall,
	output rpd_out_t result
);

	logic     valid_s1;
	rpd_in_t  item_s1;
	logic     valid_s2;
	rpd_out_t result_s2;
	logic     s2_ready;
	logic     fire;
	logic     res_valid;
	rpd_out_t res;

	assign s2_ready   = !(valid_s2 && result_stall);
	assign fire       = valid_s1 && s2_ready;
	assign item_stall = valid_s1 && !s2_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!item_stall) begin
			valid_s1 <= item_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (!item_stall && item_valid) begin
			item_s1 <= item;
		end
	end

	rpd_core #(
		.MAX_PAYLOAD(MAX_PAYLOAD)
	) u_core (
		.clk      (clk),
		.arst_n   (arst_n),
		.fire     (fire),
		.item     (item_s1),
		.res_valid(res_valid),
		.res      (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (s2_ready) begin
			valid_s2 <= res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (s2_ready && res_valid) begin
			result_s2 <= res;
		end
	end

	assign result_valid = valid_s2;
	assign result       = result_s2;

endmodule

@@ hw/rtl/rpd_core.sv @@
// ----------------------------------------------------------------------------
// rpd_core
// Packet state and per-byte decode: hunting, payload sum, checksum digits, the
// verdict and the hold after an accept. One request is consumed per cycle when fire is high.
// ----------------------------------------------------------------------------
module rpd_core
	import rpd_pkg::*;
#(
	parameter int unsigned MAX_PAYLOAD = 1024
) (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     fire,
	input  rpd_in_t  item,
	output logic     res_valid,
	output rpd_out_t res
);

	localparam int unsigned PosW = $clog2(MAX_PAYLOAD);
	localparam int unsigned LenW = PosW + 1;
	localparam int unsigned CmpW = (LenW > IdxW) ? LenW : IdxW;
	localparam logic [PosW-1:0] LastPos = PosW'(MAX_PAYLOAD - 1);
	localparam logic [CmpW-1:0] IdxMax = CmpW'((1 << IdxW) - 1);

	rpd_phase_t      phase_q, phase_d;
	logic [7:0]      sum_q, sum_d;
	logic [3:0]      hi_q, hi_d;
	logic            dig_q, dig_d;
	logic [PosW-1:0] pos_q, pos_d;
	logic            ovf_q, ovf_d;
	logic            last_q, last_d;

	logic [LenW-1:0] len;
	logic [CmpW-1:0] len_ext;
	logic [CmpW-1:0] pos_ext;
	logic [IdxW-1:0] len_sat;
	logic [3:0]      digit;

	function automatic logic [3:0] hex_value(input logic [7:0] c);
		logic [3:0] v;
		v = 4'd0;
		if (c >= 8'h61 && c <= 8'h66) begin
			v = 4'(c - 8'h57);
		end else if (c >= 8'h41 && c <= 8'h46) begin
			v = 4'(c - 8'h37);
		end else if (c >= 8'h30 && c <= 8'h39) begin
			v = 4'(c - 8'h30);
		end
		return v;
	endfunction

	assign digit   = hex_value(item.rx_byte);
	assign len     = LenW'(pos_q) + LenW'(last_q);
	assign len_ext = CmpW'(len);
	assign pos_ext = CmpW'(pos_q);
	assign len_sat = (len_ext > IdxMax) ? IdxMax[IdxW-1:0] : len_ext[IdxW-1:0];

	always_comb begin
		phase_d   = phase_q;
		sum_d     = sum_q;
		hi_d      = hi_q;
		dig_d     = dig_q;
		pos_d     = pos_q;
		ovf_d     = ovf_q;
		last_d    = last_q;
		res_valid = 1'b0;
		res       = '0;
		if (fire) begin
			if (item.cmd == CMD_RELEASE) begin
				phase_d = PH_HUNT;
			end else begin
				unique case (phase_q)
					PH_HUNT: begin
						if (item.rx_byte == CH_START) begin
							phase_d = PH_PAYLOAD;
							sum_d   = '0;
							hi_d    = '0;
							dig_d   = 1'b0;
							pos_d   = '0;
							ovf_d   = 1'b0;
							last_d  = 1'b0;
						end
					end
					PH_PAYLOAD: begin
						if (item.rx_byte == CH_END) begin
							phase_d = PH_DIGITS;
							dig_d   = 1'b0;
						end else begin
							sum_d = sum_q + item.rx_byte;
							if (last_q) begin
								ovf_d = 1'b1;
							end else if (pos_q == LastPos) begin
								last_d = 1'b1;
							end else begin
								pos_d = pos_q + PosW'(1);
							end
							res_valid         = 1'b1;
							res.kind          = KIND_PAYLOAD;
							res.data          = item.rx_byte;
							res.payload_index = pos_ext[IdxW-1:0];
							res.overflow      = ovf_d;
						end
					end
					PH_DIGITS: begin
						if (!dig_q) begin
							hi_d  = digit;
							dig_d = 1'b1;
						end else begin
							dig_d             = 1'b0;
							res_valid         = 1'b1;
							res.payload_index = len_sat;
							res.overflow      = ovf_q;
							if ({hi_q, digit} == sum_q) begin
								phase_d  = PH_HOLD;
								res.kind = KIND_ACCEPT;
								res.data = CH_ACK;
							end else begin
								phase_d  = PH_HUNT;
								res.kind = KIND_REJECT;
								res.data = CH_NAK;
							end
						end
					end
					PH_HOLD: begin
					end
					default: begin
						phase_d = PH_HUNT;
					end
				endcase
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_HUNT;
			sum_q   <= '0;
			hi_q    <= '0;
			dig_q   <= 1'b0;
			pos_q   <= '0;
			ovf_q   <= 1'b0;
			last_q  <= 1'b0;
		end else begin
			phase_q <= phase_d;
			sum_q   <= sum_d;
			hi_q    <= hi_d;
			dig_q   <= dig_d;
			pos_q   <= pos_d;
			ovf_q   <= ovf_d;
			last_q  <= last_d;
		end
	end

endmodule

@@ hw/rtl/rpd_checker.sv @@
// ----------------------------------------------------------------------------
// rpd_checker
// Port-level checks for the packet deframer, bound to the top level.
// ----------------------------------------------------------------------------
module rpd_checker
	import rpd_pkg::*;
(
	input logic     clk,
	input logic     arst_n,
	input logic     item_valid,
	input logic     item_stall,
	input rpd_in_t  item,
	input logic     result_valid,
	input logic     result_stall,
	input rpd_out_t result
);

	a_item_hold: assert property (@(posedge clk) disable iff (!arst_n)
		item_valid && item_stall |=> item_valid && $stable(item))
		else $error("Stalled request changed or was withdrawn.");

	a_result_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_stall |=> result_valid && $stable(result))
		else $error("Stalled result changed or was dropped.");

	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		item_stall |-> result_valid && result_stall)
		else $error("Item channel stalled while the result channel was free.");

	a_kind_code: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> result.kind == KIND_PAYLOAD || result.kind == KIND_ACCEPT ||
			result.kind == KIND_REJECT)
		else $error("Result carries an unused kind code.");

	a_verdict_char: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result.kind != KIND_PAYLOAD |->
			(result.kind == KIND_ACCEPT && result.data == CH_ACK) ||
			(result.kind == KIND_REJECT && result.data == CH_NAK))
		else $error("Verdict result carries the wrong acknowledge character.");

endmodule

bind rsp_packet_deframer rpd_checker u_rpd_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.item_valid  (item_valid),
	.item_stall  (item_stall),
	.item        (item),
	.result_valid(result_valid),
	.result_stall(result_stall),
	.result      (result)
);
